// File: hw/rtl/lllr_pkg.sv
// Package for the link loss recovery timers block.
// Holds the word types, message, role, operation and register index codes.
// No dependencies.
`timescale 1ns / 1ps

package lllr_pkg;

  localparam int unsigned MaskW      = 4;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned CfgIdxW    = 2;

  // Operation codes of an input word.
  localparam logic OpWatch  = 1'b0;
  localparam logic OpCancel = 1'b1;

  // Message codes of a result word.
  localparam logic [1:0] MsgLossRecovery     = 2'd0;
  localparam logic [1:0] MsgRecoveryFailed   = 2'd1;
  localparam logic [1:0] MsgLossDisconnected = 2'd2;
  localparam logic [1:0] MsgRecovered        = 2'd3;

  // Link roles. The fourth code behaves as neutral.
  localparam logic [1:0] RoleNeutral = 2'd0;
  localparam logic [1:0] RoleChild   = 2'd1;
  localparam logic [1:0] RoleParent  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRecoveryEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRecoveryPeriod = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRole           = 2'd2;

  typedef struct packed {
    logic             op;
    logic [MaskW-1:0] lost_slots;
    logic             loss_by_disconnect;
    logic [MaskW-1:0] recovered_slots;
    logic [MaskW-1:0] target_slots;
    logic [MaskW-1:0] current_loss_slots;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       message;
    logic [MaskW-1:0] slots;
    logic             reason_out;
    logic [MaskW-1:0] disconnect_slots;
    logic             disconnect_occurred;
    logic             last;
  } out_word_t;

endpackage

// File: hw/rtl/link_loss_recovery_timers.sv
// Link loss recovery timers: per-slot link supervisor, top level.
// Depends on lllr_pkg for the word types and the code constants.
`timescale 1ns / 1ps

// How the block is used
// ---------------------
// The input channel (in_valid_i, in_stall_o, in_word_i) takes one word per
// watch tick or cancel request. A word is taken at a rising edge where
// in_valid_i is high and in_stall_o is low. The output channel (out_valid_o,
// out_stall_i, out_word_o) delivers the messages that each input word causes,
// zero to three of them, in order, with the last one flagged by its last bit.
// All decisions and all timer updates for one input word are made in the
// cycle in which it is taken; its messages are held in a three-entry result
// bundle and moved one per cycle, while the output register is free or being
// emptied, into the output register. The first message passes through the
// bundle and then the output register before it can be collected. An input
// word that causes at most one message can be followed by another in every
// cycle while the receiver does not stall; one that causes more messages
// holds the input stall until its final message moves out of the bundle.
// The bundle is freed while its final message enters the output register, so
// a new word is taken even while a finished message waits to be collected.
// When the receiver stalls, the output word holds and the bundle fills; the
// input stall then rises until the bundle drains. Reset clears the timers,
// the waiting mask and the configuration registers and empties the bundle
// and the output register. Configuration is to be written only while idle.

module link_loss_recovery_timers #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lllr_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lllr_pkg::out_word_t            out_word_o,
  input  logic                           cfg_we_i,
  input  logic [lllr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lllr_pkg::PeriodW-1:0]   cfg_wdata_i
);

  // Only slots that a four-bit mask can name take part.
  localparam int unsigned NumSlots =
      (SLOT_COUNT < lllr_pkg::MaskW) ? SLOT_COUNT : lllr_pkg::MaskW;
  localparam logic [lllr_pkg::MaskW-1:0] SlotMask =
      lllr_pkg::MaskW'((1 << NumSlots) - 1);

  // Configuration registers.
  logic                          recovery_enable_q;
  logic [lllr_pkg::PeriodW-1:0]  recovery_period_q;
  logic [1:0]                    role_q;

  // Timer state.
  logic [lllr_pkg::MaskW-1:0]    waiting_q, waiting_d;
  logic [lllr_pkg::PeriodW-1:0]  counter_q [NumSlots];
  logic [lllr_pkg::PeriodW-1:0]  counter_d [NumSlots];

  // Result bundle: entry 0 is the next message to move out, cnt_q is the
  // number of messages still held.
  lllr_pkg::out_word_t           bundle_q [lllr_pkg::MaxResults];
  lllr_pkg::out_word_t           bundle_d [lllr_pkg::MaxResults];
  logic [1:0]                    cnt_q, cnt_d;

  // Output register.
  logic                          out_valid_q;
  lllr_pkg::out_word_t           out_q;

  logic                          in_accept;
  logic                          move;

  // A message moves when the bundle holds one and the output register is
  // free or is being emptied in this cycle.
  assign move       = (cnt_q != 2'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && !move);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Evaluation of one input word against the current timer state.
  always_comb begin
    logic [lllr_pkg::MaskW-1:0] tgt;
    logic [lllr_pkg::MaskW-1:0] lost;
    logic [lllr_pkg::MaskW-1:0] rec;
    logic [lllr_pkg::MaskW-1:0] expired;
    logic [lllr_pkg::MaskW-1:0] dmask;
    logic                       reason;
    logic                       disc_any;
    logic [2:0]                 cand_v;
    lllr_pkg::out_word_t        cand [lllr_pkg::MaxResults];
    lllr_pkg::out_word_t        fresh [lllr_pkg::MaxResults];
    logic [1:0]                 n;

    tgt      = in_word_i.target_slots & SlotMask;
    lost     = in_word_i.lost_slots & SlotMask;
    rec      = in_word_i.recovered_slots & SlotMask;
    reason   = in_word_i.loss_by_disconnect;
    expired  = '0;
    dmask    = '0;
    disc_any = 1'b0;
    cand_v   = '0;
    for (int k = 0; k < lllr_pkg::MaxResults; k++) begin
      cand[k]  = '0;
      fresh[k] = '0;
    end
    waiting_d = waiting_q;
    for (int i = 0; i < NumSlots; i++) begin
      counter_d[i] = counter_q[i];
    end

    if (in_word_i.op == lllr_pkg::OpCancel) begin
      // A cancel only acts when one of its targets is waiting.
      if ((tgt & waiting_q) != '0) begin
        waiting_d = waiting_q & ~tgt;
        for (int i = 0; i < NumSlots; i++) begin
          if (tgt[i]) begin
            counter_d[i] = '0;
          end
        end
        dmask     = in_word_i.current_loss_slots & tgt;
        cand_v[0] = 1'b1;
        cand[0].message          = lllr_pkg::MsgRecoveryFailed;
        cand[0].slots            = dmask;
        cand[0].disconnect_slots = dmask;
      end
    end else begin
      // Loss report.
      if (lost != '0) begin
        cand_v[0]     = 1'b1;
        cand[0].slots = lost;
        if (recovery_enable_q) begin
          if ((role_q == lllr_pkg::RoleChild) && reason) begin
            cand[0].message          = lllr_pkg::MsgRecoveryFailed;
            cand[0].disconnect_slots = lost;
            disc_any                 = 1'b1;
          end else begin
            waiting_d = waiting_d | lost;
            for (int i = 0; i < NumSlots; i++) begin
              if (lost[i]) begin
                counter_d[i] = recovery_period_q;
              end
            end
            cand[0].message    = lllr_pkg::MsgLossRecovery;
            cand[0].reason_out = reason;
          end
        end else begin
          cand[0].message          = lllr_pkg::MsgLossDisconnected;
          cand[0].reason_out       = reason;
          cand[0].disconnect_slots = lost;
          disc_any                 = 1'b1;
        end
      end

      if (role_q == lllr_pkg::RoleParent) begin
        // Recovered slots end their wait.
        if (rec != '0) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (rec[i]) begin
              counter_d[i] = '0;
            end
          end
          waiting_d        = waiting_d & ~rec;
          cand_v[1]        = 1'b1;
          cand[1].message  = lllr_pkg::MsgRecovered;
          cand[1].slots    = rec;
        end
        // Countdown; a count leaving one expires its slot.
        for (int i = 0; i < NumSlots; i++) begin
          if (waiting_d[i] && (counter_d[i] != '0)) begin
            expired[i]   = (counter_d[i] == lllr_pkg::PeriodW'(1));
            counter_d[i] = counter_d[i] - lllr_pkg::PeriodW'(1);
          end
        end
        if (expired != '0) begin
          waiting_d                = waiting_d & ~expired;
          cand_v[2]                = 1'b1;
          cand[2].message          = lllr_pkg::MsgRecoveryFailed;
          cand[2].slots            = expired;
          cand[2].disconnect_slots = expired;
          disc_any                 = 1'b1;
        end
      end
    end

    // Pack the messages that occurred in order and flag the final one.
    n = 2'd0;
    for (int k = 0; k < lllr_pkg::MaxResults; k++) begin
      if (cand_v[k]) begin
        fresh[n] = cand[k];
        n        = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      fresh[n - 2'd1].last                = 1'b1;
      fresh[n - 2'd1].disconnect_occurred = disc_any;
    end

    // Bundle update: hold, shift out on a move, overwrite on an accept.
    for (int k = 0; k < lllr_pkg::MaxResults; k++) begin
      bundle_d[k] = bundle_q[k];
    end
    cnt_d = cnt_q;
    if (move) begin
      bundle_d[0] = bundle_q[1];
      bundle_d[1] = bundle_q[2];
      cnt_d       = cnt_q - 2'd1;
    end
    if (in_accept) begin
      for (int k = 0; k < lllr_pkg::MaxResults; k++) begin
        bundle_d[k] = fresh[k];
      end
      cnt_d = n;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_enable_q <= 1'b0;
      recovery_period_q <= '0;
      role_q            <= lllr_pkg::RoleNeutral;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lllr_pkg::CfgRecoveryEnable: recovery_enable_q <= cfg_wdata_i[0];
        lllr_pkg::CfgRecoveryPeriod: recovery_period_q <= cfg_wdata_i;
        lllr_pkg::CfgRole:           role_q            <= cfg_wdata_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // Timer state changes only when an input word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= '0;
      for (int i = 0; i < NumSlots; i++) begin
        counter_q[i] <= '0;
      end
    end else if (in_accept) begin
      waiting_q <= waiting_d;
      for (int i = 0; i < NumSlots; i++) begin
        counter_q[i] <= counter_d[i];
      end
    end
  end

  // Bundle count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < lllr_pkg::MaxResults; k++) begin
      bundle_q[k] <= bundle_d[k];
    end
    if (move) begin
      out_q <= bundle_q[0];
    end
  end

  // Slots that no mask bit can name never wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (waiting_q & ~SlotMask) == '0)
    else $error("waiting mask holds a slot outside the slot range");

  // The newest message held in the bundle always closes its input word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> bundle_q[cnt_q - 2'd1].last)
    else $error("result bundle lacks its final message flag");

  // The output register only fills from a non-empty bundle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(cnt_q) != 2'd0))
    else $error("output word appeared without a held message");

endmodule

// File: tb/sv/tb_link_loss_recovery_timers.sv
// Self-checking testbench for the link loss recovery timers block.
// Depends on lllr_pkg and link_loss_recovery_timers; needs nothing else to run.
`timescale 1ns / 1ps

module tb_link_loss_recovery_timers;

  localparam int unsigned SlotCount   = 4;
  localparam logic [lllr_pkg::MaskW-1:0] SlotMask =
      lllr_pkg::MaskW'((1 << SlotCount) - 1);
  // The fourth role code has no name in the package; the block treats it as neutral.
  localparam logic [1:0]  RoleSpare   = 2'd3;
  localparam int unsigned MaxGap      = 12;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldOff     = 80;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned ReportLimit = 10;

  // Timer model of the block: keeps its own copy of the registers, the waiting
  // mask and the per-slot counts, and queues the messages that each taken
  // input word must produce. Result words are then checked against that queue.
  class slot_timer_model;
    logic                         rec_en;
    logic [lllr_pkg::PeriodW-1:0] period;
    logic [1:0]                   link_role;
    logic [lllr_pkg::MaskW-1:0]   waiting;
    logic [lllr_pkg::PeriodW-1:0] remaining [SlotCount];
    lllr_pkg::out_word_t          pending_msgs [$];
    int unsigned                  mismatches;
    int unsigned                  words_checked;

    function new();
      rec_en        = 1'b0;
      period        = '0;
      link_role     = lllr_pkg::RoleNeutral;
      waiting       = '0;
      foreach (remaining[i]) remaining[i] = '0;
      mismatches    = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [lllr_pkg::CfgIdxW-1:0] idx,
                            logic [lllr_pkg::PeriodW-1:0] val);
      case (idx)
        lllr_pkg::CfgRecoveryEnable: rec_en = val[0];
        lllr_pkg::CfgRecoveryPeriod: period = val;
        lllr_pkg::CfgRole:           link_role = val[1:0];
        default: ;
      endcase
    endfunction

    function lllr_pkg::out_word_t msg(logic [1:0] code, logic [lllr_pkg::MaskW-1:0] slots,
                                      logic reason, logic [lllr_pkg::MaskW-1:0] disc);
      lllr_pkg::out_word_t w;
      w                  = '0;
      w.message          = code;
      w.slots            = slots;
      w.reason_out       = reason;
      w.disconnect_slots = disc;
      return w;
    endfunction

    function int unsigned outstanding();
      return pending_msgs.size();
    endfunction

    function void note_word(lllr_pkg::in_word_t w);
      lllr_pkg::out_word_t        res [lllr_pkg::MaxResults];
      int unsigned                n;
      int unsigned                i;
      logic [lllr_pkg::MaskW-1:0] lost;
      logic [lllr_pkg::MaskW-1:0] healed;
      logic [lllr_pkg::MaskW-1:0] tgt;
      logic [lllr_pkg::MaskW-1:0] dropped;
      logic [lllr_pkg::MaskW-1:0] expired;
      logic                       any_disc;
      n        = 0;
      any_disc = 1'b0;
      expired  = '0;

      if (w.op == lllr_pkg::OpCancel) begin
        tgt = w.target_slots & SlotMask;
        // Nothing happens unless at least one target is actually waiting.
        if ((tgt & waiting) == '0) return;
        waiting = waiting & ~tgt;
        for (i = 0; i < SlotCount; i++) begin
          if (tgt[i]) remaining[i] = '0;
        end
        dropped      = w.current_loss_slots & tgt;
        res[0]       = msg(lllr_pkg::MsgRecoveryFailed, dropped, 1'b0, dropped);
        res[0].last  = 1'b1;
        pending_msgs.push_back(res[0]);
        return;
      end

      lost   = w.lost_slots & SlotMask;
      healed = w.recovered_slots & SlotMask;

      if (lost != '0) begin
        if (!rec_en) begin
          res[n++] = msg(lllr_pkg::MsgLossDisconnected, lost, w.loss_by_disconnect, lost);
          any_disc = 1'b1;
        end else if (link_role == lllr_pkg::RoleChild && w.loss_by_disconnect) begin
          res[n++] = msg(lllr_pkg::MsgRecoveryFailed, lost, 1'b0, lost);
          any_disc = 1'b1;
        end else begin
          for (i = 0; i < SlotCount; i++) begin
            if (lost[i]) begin
              waiting[i]   = 1'b1;
              remaining[i] = period;
            end
          end
          res[n++] = msg(lllr_pkg::MsgLossRecovery, lost, w.loss_by_disconnect, '0);
        end
      end

      // Only a parent tracks recoveries and runs the countdown.
      if (link_role == lllr_pkg::RoleParent) begin
        if (healed != '0) begin
          for (i = 0; i < SlotCount; i++) begin
            if (healed[i]) remaining[i] = '0;
          end
          waiting  = waiting & ~healed;
          res[n++] = msg(lllr_pkg::MsgRecovered, healed, 1'b0, '0);
        end
        for (i = 0; i < SlotCount; i++) begin
          if (waiting[i] && remaining[i] != '0) begin
            remaining[i] = remaining[i] - lllr_pkg::PeriodW'(1);
            if (remaining[i] == '0) expired[i] = 1'b1;
          end
        end
        if (expired != '0) begin
          waiting  = waiting & ~expired;
          res[n++] = msg(lllr_pkg::MsgRecoveryFailed, expired, 1'b0, expired);
          any_disc = 1'b1;
        end
      end

      if (n > 0) begin
        res[n-1].disconnect_occurred = any_disc;
        res[n-1].last                = 1'b1;
      end
      for (i = 0; i < n; i++) pending_msgs.push_back(res[i]);
    endfunction

    function void check_word(lllr_pkg::out_word_t got);
      lllr_pkg::out_word_t want;
      words_checked++;
      if (pending_msgs.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: result word with nothing expected: msg %0d slots %h reason %0d",
                   $realtime, got.message, got.slots, got.reason_out);
        return;
      end
      want = pending_msgs.pop_front();
      if (got.message !== want.message || got.slots !== want.slots ||
          got.reason_out !== want.reason_out ||
          got.disconnect_slots !== want.disconnect_slots ||
          got.disconnect_occurred !== want.disconnect_occurred ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: result word differs (msg slots reason disc occurred last)",
                   $realtime);
          $display("  expected %0d %h %0d %h %0d %0d", want.message, want.slots,
                   want.reason_out, want.disconnect_slots, want.disconnect_occurred,
                   want.last);
          $display("  actual   %0d %h %0d %h %0d %0d", got.message, got.slots,
                   got.reason_out, got.disconnect_slots, got.disconnect_occurred,
                   got.last);
        end
      end
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  lllr_pkg::in_word_t           in_word   = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  lllr_pkg::out_word_t          out_word;
  logic                         cfg_we    = 1'b0;
  logic [lllr_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [lllr_pkg::PeriodW-1:0] cfg_wdata = '0;

  slot_timer_model board = new();

  // Idling switches for each side, set per phase, and the long receiver
  // hold-off that the stall driver picks up when it is nonzero.
  bit          tx_idle     = 1'b0;
  bit          rx_idle     = 1'b0;
  int unsigned hold_cycles = 0;

  int unsigned cycle_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned cancels_sent    = 0;
  int unsigned settings_applied = 0;

  link_loss_recovery_timers #(
    .SLOT_COUNT (SlotCount)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that hangs on a handshake ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("link_loss_recovery_timers test failed");
      $finish;
    end
  end

  // Every result word taken at an edge is checked against the oldest
  // expectation. Values are read before the edge's updates land, so the
  // outcome does not depend on the order of processes in the time step.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_word(out_word);
  end

  // Receiver stall driver. With idling on, after each taken result word it
  // may hold off for a random number of cycles. When the main sequence asks
  // for a long hold-off, the stall stays high for that many cycles, counted here.
  initial begin : out_stall_drive
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall && rx_idle) begin
        n = $urandom_range(0, MaxGap);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic lllr_pkg::in_word_t watch_word(logic [lllr_pkg::MaskW-1:0] lost,
                                                    logic reason,
                                                    logic [lllr_pkg::MaskW-1:0] healed);
    lllr_pkg::in_word_t w;
    w.op                 = lllr_pkg::OpWatch;
    w.lost_slots         = lost;
    w.loss_by_disconnect = reason;
    w.recovered_slots    = healed;
    // Fields that a watch ignores still carry random bits.
    w.target_slots       = lllr_pkg::MaskW'($urandom_range(0, 15));
    w.current_loss_slots = lllr_pkg::MaskW'($urandom_range(0, 15));
    return w;
  endfunction

  function automatic lllr_pkg::in_word_t cancel_word(logic [lllr_pkg::MaskW-1:0] tgt,
                                                     logic [lllr_pkg::MaskW-1:0] cur);
    lllr_pkg::in_word_t w;
    w.op                 = lllr_pkg::OpCancel;
    w.lost_slots         = lllr_pkg::MaskW'($urandom_range(0, 15));
    w.loss_by_disconnect = 1'($urandom_range(0, 1));
    w.recovered_slots    = lllr_pkg::MaskW'($urandom_range(0, 15));
    w.target_slots       = tgt;
    w.current_loss_slots = cur;
    return w;
  endfunction

  // Offers one input word and returns in the time step of the edge that takes
  // it. With no gap drawn, valid simply stays high into the next word, so it is
  // never lowered and raised within one time step.
  task automatic send_word(lllr_pkg::in_word_t w);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
    words_sent++;
    if (w.op == lllr_pkg::OpCancel) cancels_sent++;
  endtask

  // Brings the block to rest: no word offered, every expected result in, and
  // a drain wait for a word that was taken but causes no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [lllr_pkg::CfgIdxW-1:0] idx,
                           logic [lllr_pkg::PeriodW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // Writes all three registers back to back; the write enable drops only once
  // the last has been taken.
  task automatic apply_settings(logic en, logic [lllr_pkg::PeriodW-1:0] per,
                                logic [1:0] role);
    write_reg(lllr_pkg::CfgRecoveryEnable, lllr_pkg::PeriodW'(en));
    write_reg(lllr_pkg::CfgRecoveryPeriod, per);
    write_reg(lllr_pkg::CfgRole, lllr_pkg::PeriodW'(role));
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic run_directed();
    // Recovery off: every loss disconnects at once; an empty watch and a
    // cancel with nothing waiting produce nothing.
    settle();
    apply_settings(1'b0, 16'd0, lllr_pkg::RoleNeutral);
    send_word(watch_word(4'hF, 1'b1, 4'h0));
    send_word(watch_word(4'h0, 1'b0, 4'hF));
    send_word(cancel_word(4'hF, 4'hF));

    // Child: an explicit disconnect cannot be recovered, a plain loss waits,
    // a cancel drops the waiting slots and a second cancel finds none.
    settle();
    apply_settings(1'b1, 16'd5, lllr_pkg::RoleChild);
    send_word(watch_word(4'h3, 1'b1, 4'h0));
    send_word(watch_word(4'h5, 1'b0, 4'h0));
    send_word(cancel_word(4'hF, 4'h4));
    send_word(cancel_word(4'hF, 4'hF));

    // Parent with a period of one: a fresh loss expires in the same watch.
    settle();
    apply_settings(1'b1, 16'd1, lllr_pkg::RoleParent);
    send_word(watch_word(4'h1, 1'b0, 4'h0));

    // Period zero: the slot waits for ever, only a recovery ends it.
    settle();
    apply_settings(1'b1, 16'd0, lllr_pkg::RoleParent);
    send_word(watch_word(4'h2, 1'b0, 4'h0));
    send_word(watch_word(4'h0, 1'b1, 4'h0));
    send_word(watch_word(4'h0, 1'b0, 4'h2));

    // Longest period: a repeated loss reloads the count, a recovery stops a
    // wait, and a cancel of waiting slots that are no longer lost reports an
    // empty mask.
    settle();
    apply_settings(1'b1, 16'hFFFF, lllr_pkg::RoleParent);
    send_word(watch_word(4'hF, 1'b1, 4'h0));
    send_word(watch_word(4'h1, 1'b0, 4'h0));
    send_word(watch_word(4'h0, 1'b0, 4'hA));
    send_word(cancel_word(4'h5, 4'h0));

    // Period two: the second watch carries a loss, a recovery and an expiry,
    // which is the full three-message case.
    settle();
    apply_settings(1'b1, 16'd2, lllr_pkg::RoleParent);
    send_word(watch_word(4'h1, 1'b0, 4'h0));
    send_word(watch_word(4'h2, 1'b0, 4'h4));

    // The spare role code behaves as neutral: no child rule, no countdown.
    settle();
    apply_settings(1'b1, 16'd5, RoleSpare);
    send_word(watch_word(4'hF, 1'b1, 4'h0));
    send_word(cancel_word(4'hF, 4'hF));

    // Recovery off in parent role: a disconnect and a recovery in one watch.
    settle();
    apply_settings(1'b0, 16'd3, lllr_pkg::RoleParent);
    send_word(watch_word(4'hF, 1'b0, 4'hF));
  endtask

  // Random words: mostly watches, about half with no loss so that waiting
  // slots get ticks to run down, and a quarter cancels.
  task automatic send_random(int unsigned count);
    int unsigned                k;
    logic [lllr_pkg::MaskW-1:0] lost;
    logic [lllr_pkg::MaskW-1:0] healed;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_word(cancel_word(lllr_pkg::MaskW'($urandom_range(0, 15)),
                              lllr_pkg::MaskW'($urandom_range(0, 15))));
      end else begin
        lost   = ($urandom_range(0, 1) == 0) ? '0 : lllr_pkg::MaskW'($urandom_range(1, 15));
        healed = ($urandom_range(0, 4) < 3) ? '0 : lllr_pkg::MaskW'($urandom_range(1, 15));
        send_word(watch_word(lost, 1'($urandom_range(0, 1)), healed));
      end
    end
  endtask

  initial begin : main_sequence
    int unsigned                  ph;
    int unsigned                  k;
    logic                         en;
    logic [1:0]                   role;
    logic [lllr_pkg::PeriodW-1:0] per;

    // Reset is held low at the start and then released for good.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    // Random phases, each under its own register setting. The first phase runs
    // with no idling on either side; later ones draw the idling per phase.
    for (ph = 0; ph < 8; ph++) begin
      settle();
      en = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0:       role = lllr_pkg::RoleNeutral;
        1:       role = lllr_pkg::RoleChild;
        2:       role = RoleSpare;
        default: role = lllr_pkg::RoleParent;
      endcase
      case ($urandom_range(0, 7))
        0:       per = '0;
        1:       per = 16'hFFFF;
        default: per = lllr_pkg::PeriodW'($urandom_range(1, 6));
      endcase
      tx_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_idle = (ph != 0) && ($urandom_range(0, 3) != 0);
      apply_settings(en, per, role);
      send_random(48);
    end

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender keeps offering words that each cause two or three messages, so
    // the result bundle fills and the input stall has to rise.
    settle();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    apply_settings(1'b1, 16'd2, lllr_pkg::RoleParent);
    hold_cycles = HoldOff;
    for (k = 0; k < 16; k++) begin
      send_word(watch_word(lllr_pkg::MaskW'($urandom_range(1, 15)),
                           1'($urandom_range(0, 1)),
                           lllr_pkg::MaskW'($urandom_range(1, 15))));
    end

    settle();
    $display("Sent %0d input words (%0d cancels) under %0d register settings.",
             words_sent, cancels_sent, settings_applied);
    $display("Checked %0d result words, %0d of them wrong or unexpected.",
             board.words_checked, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("link_loss_recovery_timers test passed");
    end else begin
      $display("link_loss_recovery_timers test failed");
    end
    $finish;
  end

endmodule
